### design/tpss_pkg.sv
// ----------------------------------------------------------------------------
// tpss_pkg
// Shared widths and register codes of the triangle slice block.
// ----------------------------------------------------------------------------
package tpss_pkg;

  localparam int CoordBitsDefault = 24;
  localparam int FaceBits         = 24;
  localparam int AddrBits         = 3;

  localparam logic [AddrBits-1:0] RegSliceHeight = 3'd0;

endpackage

### design/triangle_plane_slice_segment.sv
// ----------------------------------------------------------------------------
// triangle_plane_slice_segment
// Slices one triangle per cycle at the configured height into a 2D segment.
// ----------------------------------------------------------------------------
//   channel | handshake          | words
//   in      | in_valid_i/stall_o | one triangle
//   out     | out_valid_o/stall_i| one segment (valid_res_o = 0: none)
//   cfg     | APB                | slice_height at 0x0
// One triangle per cycle unless stalled; results pass through the select and
// multiply registers, then the four-bit-per-stage divider pipeline. The whole
// pipeline holds while out_stall_i is high and a word waits.
// Reset clears valid bits and sets slice_height to 0.
module triangle_plane_slice_segment
  import tpss_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [AddrBits-1:0]          paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] ax_i, ay_i, az_i,
  input  logic signed [COORD_BITS-1:0] bx_i, by_coord_i, bz_i,
  input  logic signed [COORD_BITS-1:0] cx_i, cy_i, cz_i,
  input  logic signed [COORD_BITS-1:0] lowest_z_i,
  input  logic signed [COORD_BITS-1:0] highest_z_i,
  input  logic [FaceBits-1:0]          face_number_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         valid_res_o,
  output logic signed [COORD_BITS-1:0] start_x_o,
  output logic signed [COORD_BITS-1:0] start_y_o,
  output logic signed [COORD_BITS-1:0] end_x_o,
  output logic signed [COORD_BITS-1:0] end_y_o,
  output logic [FaceBits-1:0]          face_out_o
);

  localparam int W = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] slice_q;
  logic adv;

  logic s1_v, s1_h;
  logic [FaceBits-1:0] s1_f;
  logic signed [COORD_BITS-1:0] s1_b [4];
  logic [W-1:0] s1_m [4];
  logic s1_n [4];
  logic [W-1:0] s1_num [2];
  logic [W-1:0] s1_den [2];

  logic s2_v, s2_h;
  logic [FaceBits-1:0] s2_f;
  logic signed [COORD_BITS-1:0] s2_b [4];
  logic [2*W-1:0] s2_p [4];
  logic s2_n [4];
  logic [W-1:0] s2_d [4];

  logic signed [COORD_BITS-1:0] pt [4];

  assign pready = 1'b1;
  assign prdata = 32'($signed(slice_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= '0;
    end else if (psel && penable && pwrite && paddr == RegSliceHeight) begin
      slice_q <= pwdata[COORD_BITS-1:0];
    end
  end

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  tpss_select #(.CoordBits(COORD_BITS)) u_select (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(in_valid_i), .z_i(slice_q),
    .x0_i(ax_i), .y0_i(ay_i), .z0_i(az_i),
    .x1_i(bx_i), .y1_i(by_coord_i), .z1_i(bz_i),
    .x2_i(cx_i), .y2_i(cy_i), .z2_i(cz_i),
    .lo_i(lowest_z_i), .hi_i(highest_z_i), .face_i(face_number_i),
    .valid_o(s1_v), .hit_o(s1_h), .face_o(s1_f), .base_o(s1_b),
    .mag_o(s1_m), .neg_o(s1_n), .num_o(s1_num), .den_o(s1_den)
  );

  tpss_mul #(.CoordBits(COORD_BITS)) u_mul (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(s1_v), .hit_i(s1_h),
    .face_i(s1_f), .base_i(s1_b), .mag_i(s1_m), .neg_i(s1_n),
    .num_i(s1_num), .den_i(s1_den),
    .valid_o(s2_v), .hit_o(s2_h), .face_o(s2_f), .base_o(s2_b),
    .prod_o(s2_p), .neg_o(s2_n), .den_o(s2_d)
  );

  tpss_div #(.CoordBits(COORD_BITS)) u_div (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(s2_v), .hit_i(s2_h),
    .face_i(s2_f), .base_i(s2_b), .prod_i(s2_p), .neg_i(s2_n),
    .den_i(s2_d),
    .valid_o(out_valid_o), .hit_o(valid_res_o), .face_o(face_out_o),
    .pt_o(pt)
  );

  assign start_x_o = pt[0];
  assign start_y_o = pt[1];
  assign end_x_o   = pt[2];
  assign end_y_o   = pt[3];

endmodule

### design/tpss_select.sv
// ----------------------------------------------------------------------------
// tpss_select
// Range test, vertex pattern match and edge setup: differences and magnitudes.
// ----------------------------------------------------------------------------
module tpss_select
  import tpss_pkg::*;
#(
  parameter int CoordBits = CoordBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  logic signed [CoordBits-1:0] z_i,
  input  logic signed [CoordBits-1:0] x0_i, y0_i, z0_i,
  input  logic signed [CoordBits-1:0] x1_i, y1_i, z1_i,
  input  logic signed [CoordBits-1:0] x2_i, y2_i, z2_i,
  input  logic signed [CoordBits-1:0] lo_i,
  input  logic signed [CoordBits-1:0] hi_i,
  input  logic [FaceBits-1:0]         face_i,
  output logic                        valid_o,
  output logic                        hit_o,
  output logic [FaceBits-1:0]         face_o,
  output logic signed [CoordBits-1:0] base_o [4],
  output logic [CoordBits:0]          mag_o [4],
  output logic                        neg_o [4],
  output logic [CoordBits:0]          num_o [2],
  output logic [CoordBits:0]          den_o [2]
);

  localparam int W = CoordBits + 1;

  logic signed [CoordBits-1:0] xs [3];
  logic signed [CoordBits-1:0] ys [3];
  logic signed [CoordBits-1:0] zs [3];
  logic [1:0] p, q, r;
  logic       hit;
  logic       lt [3];
  logic       gt [3];

  logic              valid_q;
  logic              hit_q;
  logic [FaceBits-1:0] face_q;
  logic signed [CoordBits-1:0] base_q [4];
  logic [W-1:0] mag_q [4];
  logic         neg_q [4];
  logic [W-1:0] num_q [2];
  logic [W-1:0] den_q [2];

  function automatic logic [W-1:0] absw(input logic signed [W-1:0] v);
    return v[W-1] ? W'(-v) : v;
  endfunction

  always_comb begin
    xs = '{x0_i, x1_i, x2_i};
    ys = '{y0_i, y1_i, y2_i};
    zs = '{z0_i, z1_i, z2_i};
    for (int k = 0; k < 3; k++) begin
      lt[k] = zs[k] < z_i;
      gt[k] = zs[k] > z_i;
    end
    hit = 1'b1;
    p = 2'd0; q = 2'd0; r = 2'd0;
    if (z_i < lo_i || z_i > hi_i) begin
      hit = 1'b0;
    end else if (lt[0] && !lt[1] && !lt[2]) begin
      p = 2'd0; q = 2'd2; r = 2'd1;
    end else if (gt[0] && lt[1] && lt[2]) begin
      p = 2'd0; q = 2'd1; r = 2'd2;
    end else if (lt[1] && !lt[0] && !lt[2]) begin
      p = 2'd1; q = 2'd0; r = 2'd2;
    end else if (gt[1] && lt[0] && lt[2]) begin
      p = 2'd1; q = 2'd2; r = 2'd0;
    end else if (lt[2] && !lt[1] && !lt[0]) begin
      p = 2'd2; q = 2'd1; r = 2'd0;
    end else if (gt[2] && lt[1] && lt[0]) begin
      p = 2'd2; q = 2'd0; r = 2'd1;
    end else begin
      hit = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [W-1:0] dxq, dyq, dxr, dyr, nm, dq, dr;
    if (adv_i) begin
      dxq = W'(xs[q]) - W'(xs[p]);
      dyq = W'(ys[q]) - W'(ys[p]);
      dxr = W'(xs[r]) - W'(xs[p]);
      dyr = W'(ys[r]) - W'(ys[p]);
      nm  = W'(z_i) - W'(zs[p]);
      dq  = W'(zs[q]) - W'(zs[p]);
      dr  = W'(zs[r]) - W'(zs[p]);
      hit_q     <= hit;
      face_q    <= face_i;
      base_q[0] <= xs[p];
      base_q[1] <= ys[p];
      base_q[2] <= xs[p];
      base_q[3] <= ys[p];
      mag_q[0]  <= absw(dxq);
      mag_q[1]  <= absw(dyq);
      mag_q[2]  <= absw(dxr);
      mag_q[3]  <= absw(dyr);
      neg_q[0]  <= dxq[W-1] ^ nm[W-1] ^ dq[W-1];
      neg_q[1]  <= dyq[W-1] ^ nm[W-1] ^ dq[W-1];
      neg_q[2]  <= dxr[W-1] ^ nm[W-1] ^ dr[W-1];
      neg_q[3]  <= dyr[W-1] ^ nm[W-1] ^ dr[W-1];
      num_q[0]  <= absw(nm);
      num_q[1]  <= absw(nm);
      den_q[0]  <= absw(dq);
      den_q[1]  <= absw(dr);
    end
  end

  assign valid_o = valid_q;
  assign hit_o   = hit_q;
  assign face_o  = face_q;
  assign base_o  = base_q;
  assign mag_o   = mag_q;
  assign neg_o   = neg_q;
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule

### design/tpss_mul.sv
// ----------------------------------------------------------------------------
// tpss_mul
// Product stage: each edge difference magnitude times the clamped height
// offset.
// ----------------------------------------------------------------------------
module tpss_mul
  import tpss_pkg::*;
#(
  parameter int CoordBits = CoordBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  logic                        hit_i,
  input  logic [FaceBits-1:0]         face_i,
  input  logic signed [CoordBits-1:0] base_i [4],
  input  logic [CoordBits:0]          mag_i [4],
  input  logic                        neg_i [4],
  input  logic [CoordBits:0]          num_i [2],
  input  logic [CoordBits:0]          den_i [2],
  output logic                        valid_o,
  output logic                        hit_o,
  output logic [FaceBits-1:0]         face_o,
  output logic signed [CoordBits-1:0] base_o [4],
  output logic [2*CoordBits+1:0]      prod_o [4],
  output logic                        neg_o [4],
  output logic [CoordBits:0]          den_o [4]
);

  localparam int W = CoordBits + 1;

  logic valid_q, hit_q;
  logic [FaceBits-1:0] face_q;
  logic signed [CoordBits-1:0] base_q [4];
  logic [2*W-1:0] prod_q [4];
  logic neg_q [4];
  logic [W-1:0] den_q [4];
  logic [W-1:0] nc [2];

  always_comb begin
    for (int e = 0; e < 2; e++) begin
      nc[e] = (num_i[e] > den_i[e]) ? den_i[e] : num_i[e];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      hit_q  <= hit_i;
      face_q <= face_i;
      base_q <= base_i;
      neg_q  <= neg_i;
      for (int k = 0; k < 4; k++) begin
        prod_q[k] <= (2*W)'(mag_i[k]) * (2*W)'(nc[k/2]);
        den_q[k]  <= den_i[k/2];
      end
    end
  end

  assign valid_o = valid_q;
  assign hit_o   = hit_q;
  assign face_o  = face_q;
  assign base_o  = base_q;
  assign prod_o  = prod_q;
  assign neg_o   = neg_q;
  assign den_o   = den_q;

endmodule

### design/tpss_div.sv
// ----------------------------------------------------------------------------
// tpss_div
// Pipelined restoring divider: QBITS quotient bits, BitsPerStage per stage,
// four lanes side by side. Adds the signed quotient to the base at the end.
// ----------------------------------------------------------------------------
module tpss_div
  import tpss_pkg::*;
#(
  parameter int CoordBits = CoordBitsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        valid_i,
  input  logic                        hit_i,
  input  logic [FaceBits-1:0]         face_i,
  input  logic signed [CoordBits-1:0] base_i [4],
  input  logic [2*CoordBits+1:0]      prod_i [4],
  input  logic                        neg_i [4],
  input  logic [CoordBits:0]          den_i [4],
  output logic                        valid_o,
  output logic                        hit_o,
  output logic [FaceBits-1:0]         face_o,
  output logic signed [CoordBits-1:0] pt_o [4]
);

  localparam int W            = CoordBits + 1;
  localparam int PW           = 2 * W;
  localparam int QBits        = W + 1;
  localparam int BitsPerStage = 4;
  localparam int Stages       = (QBits + BitsPerStage - 1) / BitsPerStage;
  localparam int TotBits      = Stages * BitsPerStage;

  // remainder carries one extra bit over the divisor
  logic                        v_q  [Stages];
  logic                        h_q  [Stages];
  logic [FaceBits-1:0]         f_q  [Stages];
  logic signed [CoordBits-1:0] b_q  [Stages][4];
  logic                        n_q  [Stages][4];
  logic [W-1:0]                d_q  [Stages][4];
  logic [W:0]                  r_q  [Stages][4];
  logic [TotBits-1:0]          q_q  [Stages][4];
  logic [PW-1:0]               a_q  [Stages][4];

  logic [W:0]         r_in [Stages][4];
  logic [TotBits-1:0] q_in [Stages][4];
  logic [PW-1:0]      a_in [Stages][4];
  logic [W-1:0]       d_in [Stages][4];
  logic [W:0]         r_nx [Stages][4];
  logic [TotBits-1:0] q_nx [Stages][4];
  logic [PW-1:0]      a_nx [Stages][4];

  // preload the remainder with the high product bits; they stay below the divisor
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      r_in[0][k] = (W+1)'(prod_i[k] >> QBits);
      q_in[0][k] = '0;
      a_in[0][k] = prod_i[k] << (PW - QBits);
      d_in[0][k] = den_i[k];
    end
    for (int s = 1; s < Stages; s++) begin
      for (int k = 0; k < 4; k++) begin
        r_in[s][k] = r_q[s-1][k];
        q_in[s][k] = q_q[s-1][k];
        a_in[s][k] = a_q[s-1][k];
        d_in[s][k] = d_q[s-1][k];
      end
    end
    for (int s = 0; s < Stages; s++) begin
      for (int k = 0; k < 4; k++) begin
        r_nx[s][k] = r_in[s][k];
        q_nx[s][k] = q_in[s][k];
        a_nx[s][k] = a_in[s][k];
        for (int j = 0; j < BitsPerStage; j++) begin
          r_nx[s][k] = {r_nx[s][k][W-1:0], a_nx[s][k][PW-1]};
          a_nx[s][k] = a_nx[s][k] << 1;
          if (r_nx[s][k] >= (W+1)'(d_in[s][k])) begin
            r_nx[s][k] = r_nx[s][k] - (W+1)'(d_in[s][k]);
            q_nx[s][k] = {q_nx[s][k][TotBits-2:0], 1'b1};
          end else begin
            q_nx[s][k] = {q_nx[s][k][TotBits-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Stages; s++) begin
        v_q[s] <= 1'b0;
      end
    end else if (adv_i) begin
      v_q[0] <= valid_i;
      for (int s = 1; s < Stages; s++) begin
        v_q[s] <= v_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      h_q[0] <= hit_i;
      f_q[0] <= face_i;
      for (int k = 0; k < 4; k++) begin
        b_q[0][k] <= base_i[k];
        n_q[0][k] <= neg_i[k];
      end
      for (int s = 1; s < Stages; s++) begin
        h_q[s] <= h_q[s-1];
        f_q[s] <= f_q[s-1];
        for (int k = 0; k < 4; k++) begin
          b_q[s][k] <= b_q[s-1][k];
          n_q[s][k] <= n_q[s-1][k];
        end
      end
      for (int s = 0; s < Stages; s++) begin
        for (int k = 0; k < 4; k++) begin
          d_q[s][k] <= d_in[s][k];
          r_q[s][k] <= r_nx[s][k];
          q_q[s][k] <= q_nx[s][k];
          a_q[s][k] <= a_nx[s][k];
        end
      end
    end
  end

  // prod is below 2^(PW-1) and prod/den fits in W bits; extra low bits of a
  // padded stage fall off the bottom
  always_comb begin
    logic [CoordBits-1:0] qv;
    for (int k = 0; k < 4; k++) begin
      qv = CoordBits'(q_q[Stages-1][k] >> (TotBits - QBits));
      if (!h_q[Stages-1]) begin
        pt_o[k] = '0;
      end else if (n_q[Stages-1][k]) begin
        pt_o[k] = b_q[Stages-1][k] - $signed(qv);
      end else begin
        pt_o[k] = b_q[Stages-1][k] + $signed(qv);
      end
    end
  end

  assign valid_o = v_q[Stages-1];
  assign hit_o   = h_q[Stages-1];
  assign face_o  = h_q[Stages-1] ? f_q[Stages-1] : '0;

endmodule

### design/tpss_checker.sv
// ----------------------------------------------------------------------------
// tpss_checker
// Port-level checks on the slice block, bound to the top level.
// ----------------------------------------------------------------------------
module tpss_checker
  import tpss_pkg::*;
#(
  parameter int COORD_BITS = CoordBitsDefault
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic                  valid_res_o,
  input logic [COORD_BITS-1:0] start_x_o,
  input logic [FaceBits-1:0]   face_out_o
);

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)) else $error("stall without cause");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(face_out_o) && $stable(start_x_o))
    else $error("output word changed under stall");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> face_out_o == '0 && start_x_o == '0)
    else $error("empty segment not cleared");

endmodule

bind triangle_plane_slice_segment tpss_checker #(.COORD_BITS(COORD_BITS)) u_tpss_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i, .valid_res_o,
  .start_x_o, .face_out_o
);
